// ===== rtl/core/line_pattern_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// Line pattern matcher assertion macros
// Shared property shorthands for the checker of the line pattern matcher.
// ----------------------------------------------------------------------------
`ifndef LINE_PATTERN_MATCHER_DEFINES_SVH
`define LINE_PATTERN_MATCHER_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define LPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define LPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Line pattern matcher package
// Shared widths, register indexes, config and result types, byte helpers.
// ----------------------------------------------------------------------------
package lpm_pkg;

   localparam int PATTERN_MAX_DEFAULT = 16;
   localparam int PATTERN_BYTES       = 16;
   localparam int PAT_IDX_WIDTH       = $clog2(PATTERN_BYTES);
   localparam int LENGTH_WIDTH        = 5;
   localparam int CSR_DATA_WIDTH      = 64;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int LINE_INDEX_WIDTH    = 32;
   localparam int REQ_TDATA_WIDTH     = 8;
   localparam int RSP_TDATA_WIDTH     = 40;
   localparam int RSP_PAD_WIDTH       = RSP_TDATA_WIDTH - LINE_INDEX_WIDTH - 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_LENGTH       = 3'd2,
      CSR_FOLD_CASE    = 3'd3,
      CSR_WHOLE_WORD   = 3'd4,
      CSR_INVERT       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0] pattern_low;
      logic [CSR_DATA_WIDTH-1:0] pattern_high;
      logic [LENGTH_WIDTH-1:0]   length;
      logic                      fold_case;
      logic                      whole_word;
      logic                      invert;
   } cfg_type;

   typedef struct packed {
      logic [LINE_INDEX_WIDTH-1:0] line_index;
      logic                        line_selected;
   } result_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic enable);
      if (enable && c >= "A" && c <= "Z") begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

endpackage

// ===== rtl/core/lpm_csr.sv =====
// ----------------------------------------------------------------------------
// Line pattern matcher register file
// Write-only configuration registers, decoded by register index.
// ----------------------------------------------------------------------------
module lpm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [lpm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lpm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output lpm_pkg::cfg_type                     cfg
);

   lpm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (lpm_pkg::csr_index_type'(csr_index))
            lpm_pkg::CSR_PATTERN_LOW:  cfg_in.pattern_low  = csr_wdata;
            lpm_pkg::CSR_PATTERN_HIGH: cfg_in.pattern_high = csr_wdata;
            lpm_pkg::CSR_LENGTH:
               cfg_in.length = csr_wdata[lpm_pkg::LENGTH_WIDTH-1:0];
            lpm_pkg::CSR_FOLD_CASE:    cfg_in.fold_case    = csr_wdata[0];
            lpm_pkg::CSR_WHOLE_WORD:   cfg_in.whole_word   = csr_wdata[0];
            lpm_pkg::CSR_INVERT:       cfg_in.invert       = csr_wdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/lpm_match.sv =====
// ----------------------------------------------------------------------------
// Line pattern matcher window and verdict
// Byte window, parallel pattern compare, word boundary tracking, line count.
// ----------------------------------------------------------------------------
module lpm_match #(
   parameter int PATTERN_MAX = lpm_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           text_byte,
   input  logic                 byte_present,
   input  logic                 line_end,
   input  lpm_pkg::cfg_type     cfg,
   output lpm_pkg::result_type  result
);

   localparam int DEPTH     = PATTERN_MAX + 1;
   localparam int IDX_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(PATTERN_MAX + 2);
   localparam int CMP_WIDTH = (CNT_WIDTH > lpm_pkg::LENGTH_WIDTH) ? CNT_WIDTH
                                                                 : lpm_pkg::LENGTH_WIDTH;
   localparam logic [CNT_WIDTH-1:0] SEEN_MAX = CNT_WIDTH'(DEPTH);
   localparam logic [lpm_pkg::LINE_INDEX_WIDTH-1:0] COUNT_MAX = '1;

   logic [7:0]            window_ff [DEPTH];
   logic [7:0]            window_in [DEPTH];
   logic [CNT_WIDTH-1:0]  seen_ff, seen_in, seen_next;
   logic                  await_ff, await_in, await_take;
   logic                  matched_ff, matched_in, matched_take;
   logic [lpm_pkg::LINE_INDEX_WIDTH-1:0] count_ff, count_in, count_next;

   logic [CNT_WIDTH-1:0]  len_eff;
   logic [7:0]            pat_bytes [lpm_pkg::PATTERN_BYTES];
   logic [CNT_WIDTH-1:0]  pat_pos   [PATTERN_MAX];
   logic [CMP_WIDTH-1:0]  pat_pos_w [PATTERN_MAX];
   logic [7:0]            pat_sel   [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] byte_ok;
   logic                  hit, left_ok, boundary_hit, line_hit;

   always_comb begin
      if (CMP_WIDTH'(cfg.length) > CMP_WIDTH'(PATTERN_MAX)) begin
         len_eff = CNT_WIDTH'(PATTERN_MAX);
      end else begin
         len_eff = CNT_WIDTH'(cfg.length);
      end

      for (int i = 0; i < lpm_pkg::PATTERN_BYTES / 2; i++) begin
         pat_bytes[i]                              = cfg.pattern_low[8*i +: 8];
         pat_bytes[i + lpm_pkg::PATTERN_BYTES / 2] = cfg.pattern_high[8*i +: 8];
      end

      window_in[0] = text_byte;
      for (int i = 1; i < DEPTH; i++) begin
         window_in[i] = window_ff[i-1];
      end

      seen_next = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + 1'b1;

      // window slot j lines up with pattern byte len-1-j
      for (int j = 0; j < PATTERN_MAX; j++) begin
         pat_pos[j]   = len_eff - CNT_WIDTH'(j) - 1'b1;
         pat_pos_w[j] = CMP_WIDTH'(pat_pos[j]);
         if (pat_pos_w[j] < CMP_WIDTH'(lpm_pkg::PATTERN_BYTES)) begin
            pat_sel[j] = pat_bytes[pat_pos_w[j][lpm_pkg::PAT_IDX_WIDTH-1:0]];
         end else begin
            pat_sel[j] = 8'h00;
         end
         byte_ok[j] = (CNT_WIDTH'(j) >= len_eff) ||
                      (lpm_pkg::fold_byte(window_in[j], cfg.fold_case) ==
                       lpm_pkg::fold_byte(pat_sel[j], cfg.fold_case));
      end

      hit          = (len_eff != '0) && (seen_next >= len_eff) && (&byte_ok);
      left_ok      = (seen_next == len_eff) ||
                     !lpm_pkg::is_alnum(window_in[len_eff[IDX_WIDTH-1:0]]);
      boundary_hit = await_ff && !lpm_pkg::is_alnum(text_byte);

      matched_take = matched_ff || boundary_hit || (hit && !cfg.whole_word);
      await_take   = hit && cfg.whole_word && left_ok;

      // a line closes on whatever the byte of this request left behind
      if (byte_present) begin
         line_hit = matched_take || await_take;
      end else begin
         line_hit = matched_ff || await_ff;
      end
      count_next = (count_ff == COUNT_MAX) ? count_ff
                                            : count_ff + 1'b1;

      result.line_selected = (line_hit || (len_eff == '0)) ^ cfg.invert;
      result.line_index    = count_next;

      seen_in    = seen_ff;
      await_in   = await_ff;
      matched_in = matched_ff;
      count_in   = count_ff;
      if (take) begin
         if (line_end) begin
            seen_in    = '0;
            await_in   = 1'b0;
            matched_in = 1'b0;
            count_in   = count_next;
         end else if (byte_present) begin
            seen_in    = seen_next;
            await_in   = await_take;
            matched_in = matched_take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         await_ff   <= 1'b0;
         matched_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         seen_ff    <= seen_in;
         await_ff   <= await_in;
         matched_ff <= matched_in;
         count_ff   <= count_in;
      end
   end

   // window contents are only read back within the line that wrote them
   always_ff @(posedge clock) begin
      if (take && byte_present) begin
         window_ff <= window_in;
      end
   end

endmodule

// ===== rtl/core/line_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// Line pattern matcher
// Streaming substring matcher for text lines with a per-line verdict.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless a closing request waits on a full output
// register: one byte of a line in req_tdata, req_tuser set when the byte is
// real, req_tlast closing the line (req_tuser low with req_tlast high closes
// the line without adding a byte). Each closing request yields one response
// with the line verdict and its 1-based, saturating line index. A request
// waits in the input register and is folded into the line state by a
// combinational compare of a 17-byte window against the pattern; the verdict
// of a closing request is registered in the output register once that register
// is free, and the output register lets bytes keep flowing while a response
// waits. Program the pattern registers only while the stream is idle.
module line_pattern_matcher #(
   parameter int PATTERN_MAX = lpm_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lpm_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,  // [7:0] text_byte
   input  logic                                 req_tuser,  // [0] byte_present
   input  logic                                 req_tlast,  // line_end
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] line_selected, [32:1] line_index, [39:33] zero
   output logic [lpm_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                 csr_wr_en,
   input  logic [lpm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lpm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   lpm_pkg::cfg_type     cfg;
   lpm_pkg::result_type  result;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_present_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   lpm_pkg::result_type rsp_data_ff;
   logic        out_free, consume, req_fire;

   lpm_csr u_lpm_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpm_match #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_lpm_match (
      .clock        (clock),
      .reset        (reset),
      .take         (consume),
      .text_byte    (in_byte_ff),
      .byte_present (in_present_ff),
      .line_end     (in_last_ff),
      .cfg          (cfg),
      .result       (result)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   // a request that closes no line never waits on the response side
   assign consume    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || consume;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (consume && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff    <= req_tdata;
         in_present_ff <= req_tuser;
         in_last_ff    <= req_tlast;
      end
      if (consume && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{lpm_pkg::RSP_PAD_WIDTH{1'b0}},
                        rsp_data_ff.line_index, rsp_data_ff.line_selected};

endmodule

// ===== rtl/core/lpm_checker.sv =====
// ----------------------------------------------------------------------------
// Line pattern matcher checker
// Port-level properties of the response stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_pattern_matcher_defines.svh"

module lpm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [lpm_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata
);

   logic [lpm_pkg::LINE_INDEX_WIDTH-1:0] rsp_number;
   logic                                 rsp_fire;

   assign rsp_number = rsp_tdata[lpm_pkg::LINE_INDEX_WIDTH:1];
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   `LPM_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_tvalid, "response valid after reset")
   `LPM_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `LPM_ASSERT_NOW(a_number_nonzero, clock, reset, rsp_tvalid, rsp_number != '0, "line index zero")
   `LPM_ASSERT_NEXT(a_number_steps, clock, reset, rsp_fire, !rsp_tvalid || (rsp_number == $past(rsp_number) + 32'd1) || ($past(rsp_number) == '1), "line indexes not consecutive")

endmodule

bind line_pattern_matcher lpm_checker u_lpm_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pattern matcher testbench
// Streams text lines into the matcher under a range of pattern settings and
// checks every line verdict and line index against a predictor kept in step
// with each accepted request. Covers directed word-boundary and case-folding
// lines, random lines built around the pattern, random idling on both sides
// and a long response stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WINDOW          = lpm_pkg::PATTERN_MAX_DEFAULT + 1;
   localparam int DRAIN_SLACK     = 8;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int STALL_LIMIT     = 4000;
   localparam int MAX_REPORTS     = 100;

   typedef enum int {CHAR_WORD, CHAR_GAP, CHAR_ANY} char_class_type;

   logic                                  clock      = 1'b0;
   logic                                  reset      = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [lpm_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata  = '0;   // [7:0] text_byte
   logic                                  req_tuser  = 1'b0; // [0] byte_present
   logic                                  req_tlast  = 1'b0; // line_end
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   // [0] line_selected, [32:1] line_index, [39:33] zero
   logic [lpm_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata;
   logic                                  csr_wr_en  = 1'b0;
   logic [lpm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index  = '0;
   logic [lpm_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata  = '0;

   // predicted line state and register copy
   lpm_pkg::cfg_type                      active_cfg = '0;
   logic [7:0]                            recent_chars [WINDOW] = '{default: 8'h00};
   logic [4:0]                            chars_in_line    = '0;
   logic                                  word_end_pending = 1'b0;
   logic                                  line_hit         = 1'b0;
   logic [lpm_pkg::LINE_INDEX_WIDTH-1:0]  lines_closed     = '0;
   lpm_pkg::result_type                   expected_verdicts [$];

   int send_idle_pct    = 0;
   int recv_idle_pct    = 0;
   int rsp_hold_left    = 0;
   int quiet_cycles     = 0;
   int items_sent       = 0;
   int lines_checked    = 0;
   int settings_applied = 0;
   int fail_count       = 0;

   line_pattern_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic logic [7:0] fold_char(input logic [7:0] c);
      if (active_cfg.fold_case && c >= "A" && c <= "Z") begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic [7:0] pattern_char(input int k);
      if (k < 8) begin
         return active_cfg.pattern_low[8*k +: 8];
      end
      if (k < 16) begin
         return active_cfg.pattern_high[8*(k-8) +: 8];
      end
      return 8'h00;
   endfunction

   function automatic int active_length();
      if (active_cfg.length > lpm_pkg::PATTERN_MAX_DEFAULT) begin
         return lpm_pkg::PATTERN_MAX_DEFAULT;
      end
      return int'(active_cfg.length);
   endfunction

   function automatic void absorb_char(input logic [7:0] c);
      int  n;
      logic hit;
      n = active_length();
      // resolve a whole-word candidate that ended on the previous byte
      if (word_end_pending && !is_word_char(c)) begin
         line_hit = 1'b1;
      end
      word_end_pending = 1'b0;
      for (int i = WINDOW - 1; i > 0; i--) begin
         recent_chars[i] = recent_chars[i-1];
      end
      recent_chars[0] = c;
      if (chars_in_line < WINDOW) begin
         chars_in_line++;
      end
      if (n == 0 || chars_in_line < n) begin
         return;
      end
      hit = 1'b1;
      for (int k = 0; k < n; k++) begin
         if (fold_char(recent_chars[n-1-k]) != fold_char(pattern_char(k))) begin
            hit = 1'b0;
         end
      end
      if (!hit) begin
         return;
      end
      if (!active_cfg.whole_word) begin
         line_hit = 1'b1;
      end else if (chars_in_line == n || !is_word_char(recent_chars[n])) begin
         word_end_pending = 1'b1;
      end
   endfunction

   function automatic void update_line_state(input logic [7:0] c, input logic present,
                                             input logic last);
      lpm_pkg::result_type verdict;
      logic                matched;
      if (present) begin
         absorb_char(c);
      end
      if (last) begin
         matched = line_hit || word_end_pending || active_length() == 0;
         if (lines_closed != '1) begin
            lines_closed++;
         end
         verdict.line_selected = matched ^ active_cfg.invert;
         verdict.line_index    = lines_closed;
         expected_verdicts.push_back(verdict);
         chars_in_line    = '0;
         word_end_pending = 1'b0;
         line_hit         = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Response side: ready generation, verdict check, watchdog
   // ------------------------------------------------------------------------
   function automatic void report_mismatch(input string what, input logic [63:0] want,
                                           input logic [63:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : verdict_check
      lpm_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch("unexpected response", '0, rsp_tdata);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_tdata[0] !== want.line_selected) begin
               report_mismatch("line_selected", want.line_selected, rsp_tdata[0]);
            end
            if (rsp_tdata[lpm_pkg::LINE_INDEX_WIDTH:1] !== want.line_index) begin
               report_mismatch("line_index", want.line_index,
                               rsp_tdata[lpm_pkg::LINE_INDEX_WIDTH:1]);
            end
            if (rsp_tdata[lpm_pkg::RSP_TDATA_WIDTH-1:lpm_pkg::LINE_INDEX_WIDTH+1] !== '0) begin
               report_mismatch("padding", '0,
                               rsp_tdata[lpm_pkg::RSP_TDATA_WIDTH-1:lpm_pkg::LINE_INDEX_WIDTH+1]);
            end
            lines_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d verdicts outstanding",
                  $time, quiet_cycles, expected_verdicts.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   task automatic send_req(input logic [7:0] c, input logic present, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= present;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      update_line_state(c, present, last);
      if (present || last) begin
         items_sent++;
      end
   endtask

   // drop valid, wait for every verdict, then let the pipeline settle
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // hold the write enable high; the caller drops it after the last write
   task automatic write_reg(input lpm_pkg::csr_index_type idx, input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         lpm_pkg::CSR_PATTERN_LOW:  active_cfg.pattern_low  = value;
         lpm_pkg::CSR_PATTERN_HIGH: active_cfg.pattern_high = value;
         lpm_pkg::CSR_LENGTH:       active_cfg.length = value[lpm_pkg::LENGTH_WIDTH-1:0];
         lpm_pkg::CSR_FOLD_CASE:    active_cfg.fold_case    = value[0];
         lpm_pkg::CSR_WHOLE_WORD:   active_cfg.whole_word   = value[0];
         lpm_pkg::CSR_INVERT:       active_cfg.invert       = value[0];
         default: ;
      endcase
   endtask

   // narrow registers get random upper bits, which the block must ignore
   task automatic program_config(input lpm_pkg::cfg_type c);
      write_reg(lpm_pkg::CSR_PATTERN_LOW, c.pattern_low);
      write_reg(lpm_pkg::CSR_PATTERN_HIGH, c.pattern_high);
      write_reg(lpm_pkg::CSR_LENGTH, {32'($urandom), 27'($urandom), c.length});
      write_reg(lpm_pkg::CSR_FOLD_CASE, {32'($urandom), 31'($urandom), c.fold_case});
      write_reg(lpm_pkg::CSR_WHOLE_WORD, {32'($urandom), 31'($urandom), c.whole_word});
      write_reg(lpm_pkg::CSR_INVERT, {32'($urandom), 31'($urandom), c.invert});
      csr_wr_en <= 1'b0;
      settings_applied++;
   endtask

   function automatic logic [7:0] pick_char(input int cls);
      case (cls)
         CHAR_WORD: begin
            case ($urandom_range(2))
               0:       return 8'("a" + $urandom_range(25));
               1:       return 8'("A" + $urandom_range(25));
               default: return 8'("0" + $urandom_range(9));
            endcase
         end
         CHAR_GAP: begin
            case ($urandom_range(5))
               0:       return " ";
               1:       return ".";
               2:       return "-";
               3:       return "_";
               4:       return 8'h09;
               default: return 8'h00;
            endcase
         end
         default: return 8'($urandom);
      endcase
   endfunction

   // the first phases of each run pin the extremes, the rest are random
   function automatic lpm_pkg::cfg_type random_setting(input int phase);
      lpm_pkg::cfg_type c;
      int               roll;
      logic [7:0]       c_byte;
      for (int k = 0; k < lpm_pkg::PATTERN_BYTES; k++) begin
         roll   = $urandom_range(19);
         c_byte = pick_char(roll < 13 ? CHAR_WORD : (roll < 17 ? CHAR_GAP : CHAR_ANY));
         if (k < 8) begin
            c.pattern_low[8*k +: 8] = c_byte;
         end else begin
            c.pattern_high[8*(k-8) +: 8] = c_byte;
         end
      end
      roll = $urandom_range(19);
      if (roll == 0) begin
         c.length = 5'd0;
      end else if (roll == 1) begin
         c.length = 5'd16;
      end else if (roll == 2) begin
         c.length = 5'($urandom_range(17, 31));
      end else begin
         c.length = 5'($urandom_range(1, 6));
      end
      c.fold_case  = 1'($urandom_range(1));
      c.whole_word = 1'($urandom_range(1));
      c.invert     = 1'($urandom_range(1));
      case (phase)
         0: begin
            c.length = 5'd16; c.fold_case = 1'b1; c.whole_word = 1'b1; c.invert = 1'b0;
         end
         1: begin
            c.length = 5'd31; c.fold_case = 1'b0; c.whole_word = 1'b0; c.invert = 1'b1;
         end
         2: begin
            c.length = 5'd0; c.whole_word = 1'b1; c.invert = 1'b0;
         end
         3: begin
            c.pattern_low = '1; c.length = 5'd3; c.fold_case = 1'b1; c.whole_word = 1'b0;
         end
         default: ;
      endcase
      return c;
   endfunction

   // a line of pattern copies, broken copies, words, gaps and raw bytes
   task automatic send_random_line();
      logic [7:0] text [$];
      logic [7:0] c;
      int         segments;
      int         roll;
      int         run;
      int         plen;
      logic       close_alone;
      plen     = active_length();
      segments = ($urandom_range(24) == 0) ? $urandom_range(12, 24) : $urandom_range(4);
      for (int s = 0; s < segments; s++) begin
         roll = $urandom_range(9);
         if (roll < 5 && plen > 0) begin
            run = (roll < 4) ? plen : $urandom_range(plen - 1);
            for (int k = 0; k < run; k++) begin
               c = pattern_char(k);
               if ($urandom_range(3) == 0 && (c | 8'h20) >= "a" && (c | 8'h20) <= "z") begin
                  c ^= 8'h20;
               end
               text.push_back(c);
            end
         end else begin
            run = $urandom_range(1, 4);
            for (int k = 0; k < run; k++) begin
               text.push_back(pick_char(roll < 7 ? CHAR_WORD : (roll < 9 ? CHAR_GAP : CHAR_ANY)));
            end
         end
      end
      close_alone = (text.size() == 0) || ($urandom_range(3) == 0);
      foreach (text[i]) begin
         if ($urandom_range(29) == 0) begin
            send_req(8'($urandom), 1'b0, 1'b0);
         end
         send_req(text[i], 1'b1, !close_alone && i == text.size() - 1);
      end
      if (close_alone) begin
         send_req(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      lpm_pkg::cfg_type c;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // reset settings: empty pattern selects every line
      send_req(8'hA5, 1'b0, 1'b1);
      send_req(8'h5A, 1'b0, 1'b0);
      send_req(8'h00, 1'b1, 1'b1);
      wait_results_drained();

      c              = '0;
      c.pattern_low  = 64'h0000_0000_0000_6261;
      c.length       = 5'd2;
      c.fold_case    = 1'b1;
      c.whole_word   = 1'b1;
      program_config(c);
      send_req("A", 1'b1, 1'b0);
      send_req("b", 1'b1, 1'b0);
      send_req("!", 1'b1, 1'b1);
      send_req("a", 1'b1, 1'b0);
      send_req("b", 1'b1, 1'b0);
      send_req("c", 1'b1, 1'b1);
      // first occurrence runs into a letter, the second ends the line
      send_req("a", 1'b1, 1'b0);
      send_req("b", 1'b1, 1'b0);
      send_req("x", 1'b1, 1'b0);
      send_req(" ", 1'b1, 1'b0);
      send_req("a", 1'b1, 1'b0);
      send_req("b", 1'b1, 1'b1);
      // leave a word candidate pending across a register write
      send_req("a", 1'b1, 1'b0);
      send_req("b", 1'b1, 1'b0);
      wait_results_drained();
      write_reg(lpm_pkg::CSR_INVERT, 64'h1);
      csr_wr_en <= 1'b0;
      send_req(".", 1'b1, 1'b1);
      send_req(8'hFF, 1'b1, 1'b0);
      send_req(8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
      int phase;
      int stop_at;
      int phase_end;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at       = items_sent + count;
      phase         = 0;
      while (items_sent < stop_at) begin
         wait_results_drained();
         program_config(random_setting(phase));
         phase_end = items_sent + $urandom_range(60, 140);
         while (items_sent < phase_end && items_sent < stop_at) begin
            send_random_line();
         end
         phase++;
      end
   endtask

   // hold off the receiver while one-item lines keep coming, so the input stalls
   task automatic test_input_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_results_drained();
      program_config(random_setting(-1));
      @(negedge clock);
      rsp_hold_left = RSP_HOLD_CYCLES;
      @(posedge clock);
      repeat (120) send_req(pick_char(CHAR_WORD), 1'($urandom_range(1)), 1'b1);
      wait_results_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic(17, 48, 650);
      test_random_traffic(48, 17, 650);
      test_input_stall();
      test_random_traffic(0, 0, 650);
      wait_results_drained();
      $display("Streamed %0d text requests and checked %0d line verdicts over %0d settings,",
               items_sent, lines_checked, settings_applied);
      $display("with idling on both sides, a long response stall and %0d mismatches.",
               fail_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lpm_pkg.sv
rtl/core/lpm_csr.sv
rtl/core/lpm_match.sv
rtl/core/line_pattern_matcher.sv
rtl/core/lpm_checker.sv
dv/tb_top.sv
